// ----- rtl/core/dawu_pkg.sv -----
// Shared types, constants and calendar helpers for the date add and weekday unit.
// No dependencies; used by dawu_ctrl, dawu_dp and the top level.
package dawu_pkg;

  localparam int unsigned YEAR_MIN    = 1900;
  localparam int unsigned YEAR_MAX    = 16383;
  localparam int unsigned CYCLE_YEARS = 400;
  localparam int unsigned CENTURY     = 100;
  localparam int unsigned ZEL_BIAS    = 355;  // 5 plus a multiple of 7, keeps the sum positive

  localparam logic [8:0] YEAR_MIN_R400 = 9'(YEAR_MIN % CYCLE_YEARS);
  localparam logic [8:0] CENT_1        = 9'(CENTURY);
  localparam logic [8:0] CENT_2        = 9'(2 * CENTURY);
  localparam logic [8:0] CENT_3        = 9'(3 * CENTURY);

  typedef enum logic [1:0] {
    OP_DAYS   = 2'd0,
    OP_MONTHS = 2'd1,
    OP_YEARS  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ACT_IDLE,
    ACT_LOAD,
    ACT_CHECK,
    ACT_DAYS_INIT,
    ACT_WALK,
    ACT_DAYS_END,
    ACT_MONTHS,
    ACT_YEARS_DIV,
    ACT_YEARS_CHK,
    ACT_WDAY_DIV,
    ACT_ZELLER,
    ACT_OUT
  } act_e;

  typedef struct packed {
    act_e act;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic div_done;
    logic walk_done;
    logic yr_in_range;
  } sts_t;

  // leap test from the year modulo 400
  function automatic logic is_leap(input logic [8:0] r400);
    return (r400[1:0] == 2'd0) && (r400 != CENT_1) && (r400 != CENT_2) && (r400 != CENT_3);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // (13 * (m + 1)) / 5 for the shifted months 3 to 14
  function automatic logic [5:0] zel_month_term(input logic [3:0] m);
    logic [5:0] t;
    case (m)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // 8 is 1 mod 7: fold octal digits, then one conditional subtract
  function automatic logic [2:0] mod7(input logic [9:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

// ----- rtl/core/dawu_dp.sv -----
// Datapath of the date add and weekday unit: date registers, month walker,
// divide-by-400 subtractor, Zeller sum and result word. Depends on dawu_pkg.
module dawu_dp (
  input  logic               clk_i,
  input  dawu_pkg::cmd_t     cmd_i,
  output dawu_pkg::sts_t     sts_o,
  input  logic [1:0]         op_i,
  input  logic [5:0]         in_day_i,
  input  logic [3:0]         in_month_i,
  input  logic [13:0]        in_year_i,
  input  logic signed [15:0] amount_i,
  output logic               ok_o,
  output logic               date_replaced_o,
  output logic [4:0]         out_day_o,
  output logic [3:0]         out_month_o,
  output logic [13:0]        out_year_o,
  output logic [2:0]         weekday_o
);

  dawu_pkg::op_e      op_q;
  logic signed [15:0] amt_q;
  logic [5:0]         id_q;
  logic [3:0]         im_q;
  logic [13:0]        iy_q;

  logic [4:0]         bd_q;
  logic [3:0]         bm_q;
  logic [13:0]        by_q;
  logic [8:0]         br_q;
  logic               repl_q;
  logic               ok_q;

  logic signed [16:0] wd_q;
  logic [3:0]         wm_q;
  logic [14:0]        wy_q;
  logic [8:0]         wr_q;

  logic [14:0]        dv_r_q;
  logic [5:0]         dv_q_q;
  logic [9:0]         zf_q;

  logic               dv_done;
  logic [8:0]         dv_r9;
  logic               in_ok;
  logic [4:0]         chk_d;
  logic [3:0]         chk_m;
  logic [13:0]        chk_y;
  logic [8:0]         chk_r;
  logic signed [16:0] amt_x;
  logic [4:0]         cur_ml;
  logic [8:0]         wr_inc;
  logic [8:0]         wr_dec;
  logic [3:0]         pm;
  logic [8:0]         pr;
  logic [4:0]         prev_ml;
  logic               walk_done;
  logic signed [16:0] ny_sum;
  logic               yr_in_range;
  logic signed [16:0] nm_sum;
  logic               months_ok;
  logic               years_ok;
  logic               wy_ok;
  logic               wk_early;
  logic [14:0]        wk_year;
  logic [3:0]         wk_mon;
  logic [1:0]         jq;
  logic [8:0]         jsub;
  logic [6:0]         kk;
  logic [7:0]         jj;
  logic [11:0]        zsum;

  assign dv_done = (dv_r_q < 15'(dawu_pkg::CYCLE_YEARS));
  assign dv_r9   = dv_r_q[8:0];

  // input date check
  assign in_ok = (iy_q >= 14'(dawu_pkg::YEAR_MIN)) && (im_q >= 4'd1) && (im_q <= 4'd12) &&
                 (id_q != 6'd0) &&
                 (id_q <= {1'b0, dawu_pkg::month_len(im_q, dawu_pkg::is_leap(dv_r9))});
  assign chk_d = in_ok ? id_q[4:0] : 5'd1;
  assign chk_m = in_ok ? im_q : 4'd1;
  assign chk_y = in_ok ? iy_q : 14'(dawu_pkg::YEAR_MIN);
  assign chk_r = in_ok ? dv_r9 : dawu_pkg::YEAR_MIN_R400;

  assign amt_x = {amt_q[15], amt_q};

  // month walk
  assign cur_ml  = dawu_pkg::month_len(wm_q, dawu_pkg::is_leap(wr_q));
  assign wr_inc  = (wr_q == 9'(dawu_pkg::CYCLE_YEARS - 1)) ? 9'd0 : wr_q + 9'd1;
  assign wr_dec  = (wr_q == 9'd0) ? 9'(dawu_pkg::CYCLE_YEARS - 1) : wr_q - 9'd1;
  assign pm      = (wm_q == 4'd1) ? 4'd12 : wm_q - 4'd1;
  assign pr      = (wm_q == 4'd1) ? wr_dec : wr_q;
  assign prev_ml = dawu_pkg::month_len(pm, dawu_pkg::is_leap(pr));

  always_comb begin
    if (amt_q > 16'sd0) begin
      walk_done = (wd_q <= $signed({12'd0, cur_ml}));
    end else if (amt_q < 16'sd0) begin
      walk_done = (wd_q > 17'sd0);
    end else begin
      walk_done = 1'b1;
    end
  end

  assign wy_ok = (wy_q >= 15'(dawu_pkg::YEAR_MIN)) && (wy_q <= 15'(dawu_pkg::YEAR_MAX));

  // month and year adds
  assign nm_sum    = $signed({13'd0, bm_q}) + amt_x;
  assign months_ok = (nm_sum >= 17'sd1) && (nm_sum <= 17'sd12) &&
                     (bd_q <= dawu_pkg::month_len(nm_sum[3:0], dawu_pkg::is_leap(br_q)));
  assign ny_sum      = $signed({3'd0, by_q}) + amt_x;
  assign yr_in_range = (ny_sum >= $signed(17'(dawu_pkg::YEAR_MIN))) &&
                       (ny_sum <= $signed(17'(dawu_pkg::YEAR_MAX)));
  assign years_ok    = (bd_q <= dawu_pkg::month_len(bm_q, dawu_pkg::is_leap(dv_r9)));

  // Zeller
  assign wk_early = (wm_q < 4'd3);
  assign wk_year  = wy_q - {14'd0, wk_early};
  assign wk_mon   = wk_early ? wm_q + 4'd12 : wm_q;

  always_comb begin
    priority if (dv_r9 >= dawu_pkg::CENT_3) begin
      jq   = 2'd3;
      jsub = dawu_pkg::CENT_3;
    end else if (dv_r9 >= dawu_pkg::CENT_2) begin
      jq   = 2'd2;
      jsub = dawu_pkg::CENT_2;
    end else if (dv_r9 >= dawu_pkg::CENT_1) begin
      jq   = 2'd1;
      jsub = dawu_pkg::CENT_1;
    end else begin
      jq   = 2'd0;
      jsub = 9'd0;
    end
  end

  assign kk   = 7'(dv_r9 - jsub);
  assign jj   = {dv_q_q, jq};
  assign zsum = 12'(wd_q[4:0]) + 12'(dawu_pkg::zel_month_term(wk_mon)) + 12'(kk) +
                12'(kk[6:2]) + 12'(jj[7:2]) + 12'(dawu_pkg::ZEL_BIAS) - {3'd0, jj, 1'b0};

  // divide by 400: quotient and remainder, one subtract per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == dawu_pkg::ACT_LOAD) begin
      dv_r_q <= {1'b0, in_year_i};
      dv_q_q <= 6'd0;
    end else if (cmd_i.act == dawu_pkg::ACT_YEARS_DIV) begin
      dv_r_q <= ny_sum[14:0];
      dv_q_q <= 6'd0;
    end else if (cmd_i.act == dawu_pkg::ACT_WDAY_DIV) begin
      dv_r_q <= wk_year;
      dv_q_q <= 6'd0;
    end else if (cmd_i.div_step && !dv_done) begin
      dv_r_q <= dv_r_q - 15'(dawu_pkg::CYCLE_YEARS);
      dv_q_q <= dv_q_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.act)
      dawu_pkg::ACT_IDLE, dawu_pkg::ACT_YEARS_DIV, dawu_pkg::ACT_WDAY_DIV: begin
      end
      dawu_pkg::ACT_LOAD: begin
        op_q  <= dawu_pkg::op_e'(op_i);
        amt_q <= amount_i;
        id_q  <= in_day_i;
        im_q  <= in_month_i;
        iy_q  <= in_year_i;
        ok_q  <= 1'b0;
      end
      dawu_pkg::ACT_CHECK: begin
        bd_q   <= chk_d;
        bm_q   <= chk_m;
        by_q   <= chk_y;
        br_q   <= chk_r;
        repl_q <= !in_ok;
        wd_q   <= {12'd0, chk_d};
        wm_q   <= chk_m;
        wy_q   <= {1'b0, chk_y};
        wr_q   <= chk_r;
      end
      dawu_pkg::ACT_DAYS_INIT: begin
        wd_q <= $signed({12'd0, bd_q}) + amt_x;
      end
      dawu_pkg::ACT_WALK: begin
        if (amt_q > 16'sd0) begin
          wd_q <= wd_q - $signed({12'd0, cur_ml});
          if (wm_q == 4'd12) begin
            wm_q <= 4'd1;
            wy_q <= wy_q + 15'd1;
            wr_q <= wr_inc;
          end else begin
            wm_q <= wm_q + 4'd1;
          end
        end else begin
          wd_q <= wd_q + $signed({12'd0, prev_ml});
          wm_q <= pm;
          wr_q <= pr;
          if (wm_q == 4'd1) begin
            wy_q <= wy_q - 15'd1;
          end
        end
      end
      dawu_pkg::ACT_DAYS_END: begin
        ok_q <= wy_ok;
        if (!wy_ok) begin
          wd_q <= {12'd0, bd_q};
          wm_q <= bm_q;
          wy_q <= {1'b0, by_q};
          wr_q <= br_q;
        end
      end
      dawu_pkg::ACT_MONTHS: begin
        ok_q <= months_ok;
        if (months_ok) begin
          wm_q <= nm_sum[3:0];
        end
      end
      dawu_pkg::ACT_YEARS_CHK: begin
        ok_q <= years_ok;
        if (years_ok) begin
          wy_q <= ny_sum[14:0];
          wr_q <= dv_r9;
        end
      end
      dawu_pkg::ACT_ZELLER: begin
        zf_q <= zsum[9:0];
      end
      dawu_pkg::ACT_OUT: begin
        ok_o            <= ok_q;
        date_replaced_o <= repl_q;
        out_day_o       <= wd_q[4:0];
        out_month_o     <= wm_q;
        out_year_o      <= wy_q[13:0];
        weekday_o       <= dawu_pkg::mod7(zf_q);
      end
      default: begin
      end
    endcase
  end

  assign sts_o.op          = op_q;
  assign sts_o.div_done    = dv_done;
  assign sts_o.walk_done   = walk_done;
  assign sts_o.yr_in_range = yr_in_range;

endmodule

// ----- rtl/core/dawu_ctrl.sv -----
// Controller of the date add and weekday unit: sequences check, operation,
// weekday and output word. Depends on dawu_pkg; drives dawu_dp by commands.
module dawu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  dawu_pkg::sts_t sts_i,
  output dawu_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_VDIV   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_DISP   = 4'd3;
  localparam logic [3:0] S_WALK   = 4'd4;
  localparam logic [3:0] S_DEND   = 4'd5;
  localparam logic [3:0] S_YDIV   = 4'd6;
  localparam logic [3:0] S_YCHK   = 4'd7;
  localparam logic [3:0] S_WSTART = 4'd8;
  localparam logic [3:0] S_WDIV   = 4'd9;
  localparam logic [3:0] S_ZEL    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] state_q;
  logic [3:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;

  always_comb begin
    state_d         = state_q;
    out_valid_d     = out_valid_q && out_stall_i;
    cmd_o.act       = dawu_pkg::ACT_IDLE;
    cmd_o.div_step  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.act = dawu_pkg::ACT_LOAD;
          state_d   = S_VDIV;
        end
      end
      S_VDIV: begin
        if (sts_i.div_done) begin
          state_d = S_CHECK;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_CHECK: begin
        cmd_o.act = dawu_pkg::ACT_CHECK;
        state_d   = S_DISP;
      end
      S_DISP: begin
        unique case (sts_i.op)
          dawu_pkg::OP_DAYS: begin
            cmd_o.act = dawu_pkg::ACT_DAYS_INIT;
            state_d   = S_WALK;
          end
          dawu_pkg::OP_MONTHS: begin
            cmd_o.act = dawu_pkg::ACT_MONTHS;
            state_d   = S_WSTART;
          end
          dawu_pkg::OP_YEARS: begin
            if (sts_i.yr_in_range) begin
              cmd_o.act = dawu_pkg::ACT_YEARS_DIV;
              state_d   = S_YDIV;
            end else begin
              state_d = S_WSTART;
            end
          end
          default: begin
            state_d = S_WSTART;
          end
        endcase
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          state_d = S_DEND;
        end else begin
          cmd_o.act = dawu_pkg::ACT_WALK;
        end
      end
      S_DEND: begin
        cmd_o.act = dawu_pkg::ACT_DAYS_END;
        state_d   = S_WSTART;
      end
      S_YDIV: begin
        if (sts_i.div_done) begin
          state_d = S_YCHK;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_YCHK: begin
        cmd_o.act = dawu_pkg::ACT_YEARS_CHK;
        state_d   = S_WSTART;
      end
      S_WSTART: begin
        cmd_o.act = dawu_pkg::ACT_WDAY_DIV;
        state_d   = S_WDIV;
      end
      S_WDIV: begin
        if (sts_i.div_done) begin
          state_d = S_ZEL;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_ZEL: begin
        cmd_o.act = dawu_pkg::ACT_ZELLER;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.act   = dawu_pkg::ACT_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result word raised outside the output state");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_VDIV) && in_stall_o)
    else $error("accepted word did not start the date check");

  a_walk_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && !sts_i.walk_done) |=> state_q == S_WALK)
    else $error("month walk left before it finished");

  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && out_stall_i) |=> state_q == S_OUT)
    else $error("result overwritten while the previous word was stalled");
`endif

endmodule

// ----- rtl/core/date_add_and_weekday_unit.sv -----
// Top level of the date add and weekday unit: dawu_ctrl plus dawu_dp; needs dawu_pkg.
// Steps: accept, divide the year by 400, check, then a month walk for a day add (one
//   month per cycle, up to about 1080 months) or a divide by 400 of the new year for an
//   in-range year add; then a divide by 400 for the weekday, Zeller sum and output.
//   Each quotient by 400 is at most 40. A new word is taken once the result sits in
//   the output register. Reset clears the controller and output valid only.
module date_add_and_weekday_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [5:0]         in_day_i,
  input  logic [3:0]         in_month_i,
  input  logic [13:0]        in_year_i,
  input  logic signed [15:0] amount_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ok_o,
  output logic               date_replaced_o,
  output logic [4:0]         out_day_o,
  output logic [3:0]         out_month_o,
  output logic [13:0]        out_year_o,
  output logic [2:0]         weekday_o
);

  dawu_pkg::cmd_t cmd;
  dawu_pkg::sts_t sts;

  dawu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dawu_dp u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .in_day_i        (in_day_i),
    .in_month_i      (in_month_i),
    .in_year_i       (in_year_i),
    .amount_i        (amount_i),
    .ok_o            (ok_o),
    .date_replaced_o (date_replaced_o),
    .out_day_o       (out_day_o),
    .out_month_o     (out_month_o),
    .out_year_o      (out_year_o),
    .weekday_o       (weekday_o)
  );

endmodule
